// ===== sv/chkv_pkg.sv =====
// Shared types and hash helpers for the chained hash key-value map.
`timescale 1ns / 1ps
package chkv_pkg;

    localparam logic CMD_SET = 1'b0;
    localparam logic CMD_GET = 1'b1;

    typedef struct packed {
        logic        command;
        logic [31:0] key;
        logic [31:0] new_value;
        logic [31:0] hash;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [31:0] read_value;
        logic        table_full;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_NODE,
        ST_CHECK,
        ST_WRITE,
        ST_OUT
    } walk_state_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
        rotl32 = (x << r) | (x >> (32 - r));
    endfunction

endpackage

// ===== sv/chkv_ram.sv =====
// Generic RAM with one write port, one read port and registered read.
`timescale 1ns / 1ps
module chkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/chkv_front.sv =====
// Front end: accept requests and hash the key over a four-stage pipeline.
`timescale 1ns / 1ps
module chkv_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_command,
    input  logic [31:0]        in_key,
    input  logic [31:0]        in_new_value,
    output logic               q_valid,
    input  logic               q_ready,
    output chkv_pkg::req_t     q_req
);
    logic [3:0]  vld_reg;
    logic        cmd_reg [4];
    logic [31:0] key_reg [4];
    logic [31:0] val_reg [4];
    logic [31:0] h_reg   [4];
    logic        adv;
    logic [31:0] k1, h2, h3;

    // pipeline moves only when the last stage is free or drained
    assign adv      = !vld_reg[3] || q_ready;
    assign in_ready = adv;
    assign q_valid  = vld_reg[3];
    assign q_req    = '{command: cmd_reg[3], key: key_reg[3],
                        new_value: val_reg[3], hash: h_reg[3]};

    always_comb
    begin
        k1 = chkv_pkg::rotl32(h_reg[0], 15) * 32'h1b873593;
        h2 = chkv_pkg::rotl32(h_reg[1], 13) * 32'd5 + 32'he6546b64;
        h2 = h2 ^ 32'd4;
        h2 = h2 ^ (h2 >> 16);
        h3 = h_reg[2] ^ (h_reg[2] >> 13);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd_reg[0] <= in_command;
            key_reg[0] <= in_key;
            val_reg[0] <= in_new_value;
            h_reg[0]   <= in_key * 32'hcc9e2d51;
            for (int i = 1; i < 4; i++)
            begin
                cmd_reg[i] <= cmd_reg[i-1];
                key_reg[i] <= key_reg[i-1];
                val_reg[i] <= val_reg[i-1];
            end
            h_reg[1] <= k1;
            h_reg[2] <= h2 * 32'h85ebca6b;
            h_reg[3] <= (h3 * 32'hc2b2ae35) ^ ((h3 * 32'hc2b2ae35) >> 16);
        end
    end
endmodule

// ===== sv/chkv_queue.sv =====
// Two-entry request queue between front and back end.
`timescale 1ns / 1ps
module chkv_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  chkv_pkg::req_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output chkv_pkg::req_t rd_data
);
    chkv_pkg::req_t buf_reg [2];
    logic           wp_reg, rp_reg;
    logic [1:0]     cnt_reg;
    logic           push, pop;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = buf_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wp_reg] <= wr_data;
        end
    end
endmodule

// ===== sv/chkv_back.sv =====
// Back end: walk a bucket chain in memory and update or read the node pool.
`timescale 1ns / 1ps
module chkv_back #(
    parameter int BUCKET_COUNT = 1024,
    parameter int NUM_NODES    = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  chkv_pkg::req_t q_req,
    output logic           out_valid,
    input  logic           out_ready,
    output chkv_pkg::rsp_t out_rsp
);
    localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int NW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
    localparam int CW = $clog2(NUM_NODES + 1);
    // head entry: {epoch-independent valid, index}
    localparam int HW = NW + 1;

    chkv_pkg::walk_state_t state_reg, state_next;
    chkv_pkg::req_t        req_reg, req_next;
    chkv_pkg::rsp_t        rsp_reg, rsp_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         steps_reg, steps_next;
    logic [NW-1:0]         cur_reg, cur_next;
    logic                  clr_reg, clr_next;
    logic [BW-1:0]         clr_addr_reg, clr_addr_next;
    logic [BW-1:0]         bucket;
    logic [BW-1:0]         hd_raddr;

    logic          hd_we;
    logic [BW-1:0] hd_waddr;
    logic [HW-1:0] hd_wdata, hd_rdata;
    logic          nd_we_all, nd_we_val;
    logic [NW-1:0] nd_addr, nd_waddr;
    logic [31:0]   nk_rdata, nv_rdata, nv_wdata;
    logic [HW-1:0] nn_rdata, nn_wdata;

    // bucket number: hash modulo a bucket count that is a power of two
    assign bucket = BW'(q_req.hash[BW-1:0] & BW'(BUCKET_COUNT - 1));

    // keep reading the head of the request being walked once it is taken
    assign hd_raddr = (state_reg == chkv_pkg::ST_IDLE) ? bucket : req_reg.hash[BW-1:0];

    chkv_ram #(.WIDTH(HW), .DEPTH(BUCKET_COUNT)) u_head (
        .clk(clk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
        .raddr(hd_raddr), .rdata(hd_rdata));
    chkv_ram #(.WIDTH(32), .DEPTH(NUM_NODES)) u_key (
        .clk(clk), .we(nd_we_all), .waddr(nd_waddr), .wdata(req_reg.key),
        .raddr(nd_addr), .rdata(nk_rdata));
    chkv_ram #(.WIDTH(32), .DEPTH(NUM_NODES)) u_val (
        .clk(clk), .we(nd_we_val), .waddr(nd_waddr), .wdata(nv_wdata),
        .raddr(nd_addr), .rdata(nv_rdata));
    chkv_ram #(.WIDTH(HW), .DEPTH(NUM_NODES)) u_next (
        .clk(clk), .we(nd_we_all), .waddr(nd_waddr), .wdata(nn_wdata),
        .raddr(nd_addr), .rdata(nn_rdata));

    assign q_ready   = (state_reg == chkv_pkg::ST_IDLE) && !clr_reg;
    assign out_valid = state_reg == chkv_pkg::ST_OUT;
    assign out_rsp   = rsp_reg;

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        rsp_next      = rsp_reg;
        count_next    = count_reg;
        steps_next    = steps_reg;
        cur_next      = cur_reg;
        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        hd_we         = 1'b0;
        hd_waddr      = clr_addr_reg;
        hd_wdata      = '0;
        nd_we_all     = 1'b0;
        nd_we_val     = 1'b0;
        nd_waddr      = cur_reg;
        nd_addr       = cur_reg;
        nv_wdata      = req_reg.new_value;
        nn_wdata      = '0;
        case (state_reg)
            chkv_pkg::ST_IDLE:
            begin
                if (clr_reg)
                begin
                    hd_we         = 1'b1;
                    clr_addr_next = clr_addr_reg + BW'(1);
                    if (clr_addr_reg == BW'(BUCKET_COUNT - 1))
                    begin
                        clr_next = 1'b0;
                    end
                end
                else if (q_valid)
                begin
                    req_next   = q_req;
                    rsp_next   = '0;
                    steps_next = '0;
                    state_next = chkv_pkg::ST_HEAD;
                end
            end
            chkv_pkg::ST_HEAD:
            begin
                // head read data is ready; start the chain
                if (hd_rdata[NW] && count_reg != '0)
                begin
                    cur_next   = hd_rdata[NW-1:0];
                    state_next = chkv_pkg::ST_NODE;
                end
                else
                begin
                    state_next = chkv_pkg::ST_WRITE;
                end
            end
            chkv_pkg::ST_NODE:
            begin
                state_next = chkv_pkg::ST_CHECK;
            end
            chkv_pkg::ST_CHECK:
            begin
                steps_next = steps_reg + CW'(1);
                if (nk_rdata == req_reg.key)
                begin
                    rsp_next.found = 1'b1;
                    if (req_reg.command == chkv_pkg::CMD_GET)
                    begin
                        rsp_next.read_value = nv_rdata;
                        state_next          = chkv_pkg::ST_OUT;
                    end
                    else
                    begin
                        nd_we_val  = 1'b1;
                        state_next = chkv_pkg::ST_OUT;
                    end
                end
                else if (nn_rdata[NW] && steps_next != count_reg)
                begin
                    cur_next   = nn_rdata[NW-1:0];
                    nd_addr    = nn_rdata[NW-1:0];
                    state_next = chkv_pkg::ST_NODE;
                end
                else
                begin
                    state_next = chkv_pkg::ST_WRITE;
                end
            end
            chkv_pkg::ST_WRITE:
            begin
                // miss: a set links a new node at the chain head, or flags table_full if the pool is full
                state_next = chkv_pkg::ST_OUT;
                if (req_reg.command == chkv_pkg::CMD_SET)
                begin
                    if (count_reg == CW'(NUM_NODES))
                    begin
                        rsp_next.table_full = 1'b1;
                    end
                    else
                    begin
                        nd_waddr   = count_reg[NW-1:0];
                        nn_wdata   = hd_rdata;
                        nd_we_all  = 1'b1;
                        nd_we_val  = 1'b1;
                        hd_we      = 1'b1;
                        hd_waddr   = req_reg.hash[BW-1:0];
                        hd_wdata   = {1'b1, count_reg[NW-1:0]};
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            chkv_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = chkv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = chkv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= chkv_pkg::ST_IDLE;
            count_reg    <= '0;
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        rsp_reg   <= rsp_next;
        steps_reg <= steps_next;
        cur_reg   <= cur_next;
    end
endmodule

// ===== sv/chained_hash_key_value_map.sv =====
// Top level of the chained hash key-value map.
//
//  channel  dir  tdata fields (low bit up)                   tuser
//  s_axis   in   key[31:0], new_value[63:32], 64 bits        command
//  m_axis   out  read_value[31:0], table_full[32], 40 bits   found
//
// A request passes the MurmurHash3 pipeline and the queue, then the walker
// reads the bucket head, reads each chain node from the node memory and
// checks its key, and ends with the write and result (a hit skips the
// write). The walker takes a new request only when it is back in idle.
// After reset the walker clears one bucket head per cycle, all BUCKET_COUNT
// of them, before taking requests. A two-entry queue lets the hash pipeline
// keep accepting while the walker or the result side stalls.
`timescale 1ns / 1ps
module chained_hash_key_value_map #(
    parameter int BUCKET_COUNT = 1024,
    parameter int NUM_NODES    = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // key, new_value
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // read_value, table_full, zero fill
    output logic        m_axis_tuser    // found
);
    logic           q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    chkv_pkg::req_t q_in, q_out;
    chkv_pkg::rsp_t rsp;

    // hash the key while earlier requests walk their chains
    chkv_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_command(s_axis_tuser), .in_key(s_axis_tdata[31:0]),
        .in_new_value(s_axis_tdata[63:32]),
        .q_valid(q_in_valid), .q_ready(q_in_ready), .q_req(q_in));

    chkv_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(q_in_valid), .wr_ready(q_in_ready), .wr_data(q_in),
        .rd_valid(q_out_valid), .rd_ready(q_out_ready), .rd_data(q_out));

    chkv_back #(.BUCKET_COUNT(BUCKET_COUNT), .NUM_NODES(NUM_NODES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_out_valid), .q_ready(q_out_ready), .q_req(q_out),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_rsp(rsp));

    assign m_axis_tdata = {7'd0, rsp.table_full, rsp.read_value};
    assign m_axis_tuser = rsp.found;

`ifndef NO_ASSERTIONS
    // a refused set reports neither a hit nor a value
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[32] |-> !m_axis_tuser
        && m_axis_tdata[31:0] == 32'd0)
        else $error("table_full with found or value");
    // a result held under stall keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
        && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");
`endif
endmodule
